[rtl/homogeneous_vertex_transform_top_defines.svh]
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_top_defines
// assertion macros used by the transform rtl (hvt_cell)
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_TOP_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_TOP_DEFINES_SVH

// same-cycle implication
`define HVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/hvt_pkg.sv]
// ----------------------------------------------------------------------------
// hvt_pkg
// types and constants of the 4x4 homogeneous vertex transform
// ----------------------------------------------------------------------------
package hvt_pkg;

	localparam int DATA_W        = 32;
	localparam int NUM_ROWS      = 4;
	localparam int NUM_COLS      = 4;
	localparam int IDX_W         = 2;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PROD_W        = 2 * DATA_W;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_XFORM = 1'b1;

	typedef logic signed [DATA_W-1:0] elem_t;

	typedef struct packed {
		logic                    req_type;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [DATA_W-1:0] element_value;
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
		logic signed [DATA_W-1:0] vec_w;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
		logic signed [DATA_W-1:0] out_w;
		logic                    saturated;
	} rsp_t;

	// word handed from cell to cell
	typedef struct packed {
		logic                        req_type;
		logic [IDX_W-1:0]            row_index;
		logic [IDX_W-1:0]            col_index;
		logic [DATA_W-1:0]           element_value;
		logic [NUM_COLS-1:0][DATA_W-1:0] vec;
		logic [NUM_ROWS-1:0][DATA_W-1:0] res;
		logic                        saturated;
	} word_t;

endpackage

[rtl/hvt_cell.sv]
// ----------------------------------------------------------------------------
// hvt_cell
// one matrix row: holds the row, multiplies it with the passing vector,
// sums and saturates into its result slot, forwards the word
// ----------------------------------------------------------------------------
`include "homogeneous_vertex_transform_top_defines.svh"

module hvt_cell #(
	parameter int ROW       = 0,
	parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  hvt_pkg::word_t up_word,
	output logic           dn_valid,
	input  logic           dn_ready,
	output hvt_pkg::word_t dn_word
);

	localparam int SUM_W = hvt_pkg::PROD_W + 2 - FRAC_BITS;
	localparam logic [hvt_pkg::IDX_W-1:0] ROW_SEL = ROW[hvt_pkg::IDX_W-1:0];

	typedef logic signed [hvt_pkg::PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	hvt_pkg::elem_t row_q [hvt_pkg::NUM_COLS];
	prod_t          prod_s1 [hvt_pkg::NUM_COLS];
	hvt_pkg::word_t word_s1;
	hvt_pkg::word_t word_s2;
	logic           v1_q;
	logic           v2_q;

	logic           s1_free;
	logic           s2_free;
	logic           up_fire;
	logic           load_here;
	sum_t           sum;
	prod_t          shifted;
	logic           clamp;
	hvt_pkg::elem_t sat_val;
	hvt_pkg::word_t word_nx;

	assign s2_free   = !v2_q || dn_ready;
	assign s1_free   = !v1_q || s2_free;
	assign up_ready  = s1_free;
	assign up_fire   = up_valid && s1_free;
	assign load_here = (up_word.req_type == hvt_pkg::REQ_LOAD) && (up_word.row_index == ROW_SEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
				row_q[c] <= '0;
			end
		end else begin
			if (s1_free) begin
				v1_q <= up_valid;
			end
			if (s2_free) begin
				v2_q <= v1_q;
			end
			if (up_fire && load_here) begin
				row_q[up_word.col_index] <= up_word.element_value;
			end
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (up_fire) begin
			word_s1 <= up_word;
			for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
				prod_s1[c] <= $signed(row_q[c]) * $signed(up_word.vec[c]);
			end
		end
	end

	// floor shift, row sum, clamp
	always_comb begin
		sum = '0;
		for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
			shifted = prod_s1[c] >>> FRAC_BITS;
			sum     = sum + shifted[SUM_W-1:0];
		end
		clamp   = (sum[SUM_W-1:hvt_pkg::DATA_W-1] != '0) && (sum[SUM_W-1:hvt_pkg::DATA_W-1] != '1);
		sat_val = sum[hvt_pkg::DATA_W-1:0];
		if (clamp) begin
			sat_val = sum[SUM_W-1] ? {1'b1, {(hvt_pkg::DATA_W-1){1'b0}}}
				: {1'b0, {(hvt_pkg::DATA_W-1){1'b1}}};
		end
		word_nx = word_s1;
		if (word_s1.req_type == hvt_pkg::REQ_XFORM) begin
			word_nx.res[ROW]   = sat_val;
			word_nx.saturated = word_s1.saturated | clamp;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && v1_q) begin
			word_s2 <= word_nx;
		end
	end

	assign dn_valid = v2_q;
	assign dn_word  = word_s2;

	`HVT_ASSERT_NEXT(a_s2_hold, clk, arst_n, v2_q && !dn_ready, v2_q && dn_word == $past(dn_word), "stalled word changed")
	`HVT_ASSERT_NEXT(a_row_write, clk, arst_n, up_fire && load_here, row_q[$past(up_word.col_index)] == $past(up_word.element_value), "row element not written")
	`HVT_ASSERT_NOW(a_full_stall, clk, arst_n, !up_ready, v1_q && v2_q && !dn_ready, "cell refused a word with room")

endmodule

[rtl/homogeneous_vertex_transform_top.sv]
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_top
// 4x4 matrix times vector in signed fixed point, one cell per matrix row
// ----------------------------------------------------------------------------
// throughput: one word per cycle unless rsp_ready back-pressure stalls the chain;
// each of the four row cells has a multiply stage and a sum stage, and loads
// travel the same chain to stay in order
// reset: matrix clears to zero, chain empties, arst_n asynchronous active low
module homogeneous_vertex_transform_top #(
	parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hvt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hvt_pkg::rsp_t rsp
);

	logic           valid_c [hvt_pkg::NUM_ROWS+1];
	logic           ready_c [hvt_pkg::NUM_ROWS+1];
	hvt_pkg::word_t word_c  [hvt_pkg::NUM_ROWS+1];
	hvt_pkg::word_t head;
	hvt_pkg::word_t last;

	always_comb begin
		head               = '0;
		head.req_type      = req.req_type;
		head.row_index     = req.row_index;
		head.col_index     = req.col_index;
		head.element_value = req.element_value;
		head.vec[0]        = req.vec_x;
		head.vec[1]        = req.vec_y;
		head.vec[2]        = req.vec_z;
		head.vec[3]        = req.vec_w;
	end

	assign word_c[0]  = head;
	assign valid_c[0] = req_valid;
	assign req_ready  = ready_c[0];

	for (genvar r = 0; r < hvt_pkg::NUM_ROWS; r++) begin : g_cell
		hvt_cell #(
			.ROW       (r),
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[r]),
			.up_ready (ready_c[r]),
			.up_word  (word_c[r]),
			.dn_valid (valid_c[r+1]),
			.dn_ready (ready_c[r+1]),
			.dn_word  (word_c[r+1])
		);
	end

	// load words end here
	assign last = word_c[hvt_pkg::NUM_ROWS];
	assign ready_c[hvt_pkg::NUM_ROWS] = rsp_ready || (last.req_type == hvt_pkg::REQ_LOAD);
	assign rsp_valid = valid_c[hvt_pkg::NUM_ROWS] && (last.req_type == hvt_pkg::REQ_XFORM);

	assign rsp.out_x     = last.res[0];
	assign rsp.out_y     = last.res[1];
	assign rsp.out_z     = last.res[2];
	assign rsp.out_w     = last.res[3];
	assign rsp.saturated = last.saturated;

endmodule
